FILE: sv/bpfm_pkg.sv
// ============================================================================
// bpfm_pkg
// Shared types and constants for the buffer pool frame manager
// ============================================================================
package bpfm_pkg;

    localparam int FRAMES     = 16;
    localparam int PAGE_BITS  = 20;
    localparam int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_BITS   = $clog2(FRAMES + 1);
    localparam int CFG_BITS   = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 1'd1;

    typedef enum logic [2:0] {
        F_PIN   = 3'd0,
        F_UNPIN = 3'd1,
        F_DIRTY = 3'd2,
        F_FORCE = 3'd3,
        F_FLUSH = 3'd4
    } t_func;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_PINNED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_SCAN,
        S_TAIL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;     // capture the request word
        logic exec;      // apply the request, load the result
        logic scan;      // one flush step
        logic tail;      // flush closing word
        logic send;      // result word goes out
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_flush;
        logic scan_emit;   // current scan frame yields a word
        logic scan_done;   // current scan frame is the last one
        logic tail_need;   // closing word is needed
        logic out_free;    // output register can take a word
    } t_sts;

    typedef struct packed {
        logic [1:0]           status;
        logic [3:0]           frame_index;
        logic                 hit;
        logic                 read_valid;
        logic [PAGE_BITS-1:0] read_page;
        logic                 write_valid;
        logic [PAGE_BITS-1:0] write_page;
        logic                 last;
        logic [31:0]          read_total;
        logic [31:0]          write_total;
    } t_result;

    typedef struct packed {
        logic [2:0]           func;
        logic [PAGE_BITS-1:0] page_number;
    } t_request;

endpackage

FILE: sv/bpfm_if.sv
// ============================================================================
// bpfm_if
// Valid/ready channel carrying one payload word
// ============================================================================
interface bpfm_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/buffer_pool_frame_manager_top.sv
// ============================================================================
// buffer_pool_frame_manager_top
// Page frame table with pin/unpin, dirty tracking and FIFO or LRU eviction
// ============================================================================
// Input words carry func and page_number; output words carry the result of
// each request (one word, or for flush all one per flushed frame plus a
// closing word when an active frame is pinned or none was flushed). Both
// channels are valid/ready. Configuration is a write port: index 0 selects
// replacement mode, index 1 the pool size. A request is taken in idle, the
// frame table is searched in the next cycle (lookup and victim search over
// the active frames in parallel), and the result is loaded into the output
// register in the execute state once it is free. Flush all walks the active
// frames one per cycle, pausing on a frame that yields a word while the
// output register is not free. The output register holds its word while
// the receiver stalls and the sequencer waits on it. Synchronous reset empties
// the table, clears counters and restores FIFO mode with sixteen frames.
// ============================================================================
module buffer_pool_frame_manager_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpfm_if.sink        in_ch,
    bpfm_if.source      out_ch,
    input  logic        i_cfg_we,
    input  logic [bpfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpfm_pkg::CFG_BITS-1:0]  i_cfg_data
);

    bpfm_pkg::t_cmd w_cmd;
    bpfm_pkg::t_sts w_sts;

    // sequencer
    bpfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // frame table and result path
    bpfm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (in_ch.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (out_ch.valid),
        .i_res_ready (out_ch.ready),
        .o_res       (out_ch.data)
    );

endmodule

FILE: sv/bpfm_ctrl.sv
// ============================================================================
// bpfm_ctrl
// Request sequencer: lookup, execute, flush scan, result handoff
// ============================================================================
module bpfm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bpfm_pkg::t_sts    i_sts,
    output bpfm_pkg::t_cmd    o_cmd
);

    bpfm_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpfm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpfm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bpfm_pkg::S_LOOK;
            end
            bpfm_pkg::S_LOOK: begin
                n_state = i_sts.is_flush ? bpfm_pkg::S_SCAN : bpfm_pkg::S_EXEC;
            end
            bpfm_pkg::S_EXEC: begin
                if (i_sts.out_free) n_state = bpfm_pkg::S_IDLE;
            end
            bpfm_pkg::S_SCAN: begin
                if (!i_sts.scan_emit || i_sts.out_free) begin
                    if (i_sts.scan_done) n_state = bpfm_pkg::S_TAIL;
                end
            end
            bpfm_pkg::S_TAIL: begin
                if (!i_sts.tail_need) n_state = bpfm_pkg::S_IDLE;
                else if (i_sts.out_free) n_state = bpfm_pkg::S_IDLE;
            end
            default: n_state = bpfm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bpfm_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.latch  = i_in_valid;
            end
            bpfm_pkg::S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
                o_cmd.send = i_sts.out_free;
            end
            bpfm_pkg::S_SCAN: begin
                o_cmd.scan = !i_sts.scan_emit || i_sts.out_free;
                o_cmd.send = i_sts.scan_emit && i_sts.out_free;
            end
            bpfm_pkg::S_TAIL: begin
                o_cmd.tail = i_sts.tail_need && i_sts.out_free;
                o_cmd.send = i_sts.tail_need && i_sts.out_free;
            end
            default: ;
        endcase
    end

    // a word is only sent when the output register has room
    a_send_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.send |-> i_sts.out_free) else $error("send without room");
    // requests are taken only in idle
    a_latch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |-> r_state == bpfm_pkg::S_IDLE) else $error("latch outside idle");
    // a taken request goes to lookup
    a_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> r_state == bpfm_pkg::S_LOOK) else $error("no lookup");

endmodule

FILE: sv/bpfm_dp.sv
// ============================================================================
// bpfm_dp
// Frame table, lookup, victim choice, counters and output register
// ============================================================================
module bpfm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bpfm_pkg::t_cmd       i_cmd,
    output bpfm_pkg::t_sts       o_sts,
    input  bpfm_pkg::t_request   i_req,
    input  logic                 i_cfg_we,
    input  logic [bpfm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpfm_pkg::CFG_BITS-1:0]  i_cfg_data,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output bpfm_pkg::t_result    o_res
);

    localparam int N  = bpfm_pkg::FRAMES;
    localparam int IW = bpfm_pkg::IDX_BITS;
    localparam int PB = bpfm_pkg::PAGE_BITS;
    localparam int CW = bpfm_pkg::CNT_BITS;
    localparam int NP = 1 << IW;

    // frame table
    logic [PB-1:0] r_page  [N];
    logic [N-1:0]  r_valid, r_dirty;
    logic [7:0]    r_pin   [N];
    logic [31:0]   r_stamp [N];
    logic [31:0]   r_clock, r_reads, r_writes;
    logic [IW-1:0] r_fifo;
    logic          r_mode;
    logic [4:0]    r_pool;

    // request and lookup results
    logic [2:0]    r_func;
    logic [PB-1:0] r_pg;
    logic          r_found, r_vfound;
    logic [IW-1:0] r_fidx, r_vidx;
    logic [IW-1:0] r_scan;
    logic          r_pinned_any;
    logic [IW-1:0] r_pinned_idx;
    logic          r_wrote;

    logic              r_out_v;
    bpfm_pkg::t_result r_out, n_out;

    // active frame count, clamped
    logic [CW-1:0] w_n;
    always_comb begin
        if (r_pool == 5'd0) w_n = CW'(1);
        else if (32'(r_pool) > N) w_n = CW'(N);
        else w_n = CW'(r_pool);
    end

    // lookup and victim search over the active frames
    logic          w_found, w_vfound;
    logic [IW-1:0] w_fidx, w_vidx;
    logic [IW-1:0] w_fstart;
    always_comb begin
        logic          inv_f, lru_f, fifo_f;
        logic [IW-1:0] inv_i, lru_i, fifo_i;
        logic [CW:0]   p;
        logic [CW+IW-1:0] rem;
        logic          lv_f [2*NP];
        logic [IW-1:0] lv_i [2*NP];
        logic [31:0]   lv_s [2*NP];
        w_found = 1'b0; w_fidx = '0;
        inv_f = 1'b0; inv_i = '0;
        fifo_f = 1'b0; fifo_i = '0;
        // fifo start: pointer reduced by the active count, shift and subtract
        rem = (CW+IW)'(r_fifo);
        for (int k = IW - 1; k >= 0; k--) begin
            if (rem >= ((CW+IW)'(w_n) << k)) rem = rem - ((CW+IW)'(w_n) << k);
        end
        w_fstart = IW'(rem);
        for (int i = N - 1; i >= 0; i--) begin
            if (CW'(i) < w_n && r_valid[i] && r_page[i] == r_pg) begin
                w_found = 1'b1; w_fidx = IW'(i);
            end
            if (CW'(i) < w_n && r_pin[i] == 8'd0 && !r_valid[i]) begin
                inv_f = 1'b1; inv_i = IW'(i);
            end
        end
        // oldest unpinned stamp, compare tree, ties to the lower index
        for (int i = 0; i < NP; i++) begin
            lv_f[NP+i] = 1'b0; lv_i[NP+i] = IW'(i); lv_s[NP+i] = '0;
            if (i < N) begin
                lv_f[NP+i] = CW'(i) < w_n && r_pin[i] == 8'd0;
                lv_s[NP+i] = r_stamp[i];
            end
        end
        for (int j = NP - 1; j >= 1; j--) begin
            if (lv_f[2*j] && (!lv_f[2*j+1] || lv_s[2*j] <= lv_s[2*j+1])) begin
                lv_f[j] = 1'b1; lv_i[j] = lv_i[2*j]; lv_s[j] = lv_s[2*j];
            end else begin
                lv_f[j] = lv_f[2*j+1]; lv_i[j] = lv_i[2*j+1]; lv_s[j] = lv_s[2*j+1];
            end
        end
        lru_f = lv_f[1]; lru_i = lv_i[1];
        for (int k = N - 1; k >= 0; k--) begin
            p = (CW+1)'(w_fstart) + (CW+1)'(k);
            if (p >= (CW+1)'(w_n)) p = p - (CW+1)'(w_n);
            if (CW'(k) < w_n && r_pin[IW'(p)] == 8'd0) begin
                fifo_f = 1'b1; fifo_i = IW'(p);
            end
        end
        if (!r_mode) begin
            w_vfound = fifo_f; w_vidx = fifo_i;
        end else begin
            w_vfound = inv_f || lru_f; w_vidx = inv_f ? inv_i : lru_i;
        end
    end

    // lowest pinned active frame
    logic          w_pany;
    logic [IW-1:0] w_pidx;
    always_comb begin
        w_pany = 1'b0; w_pidx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (CW'(i) < w_n && r_pin[i] != 8'd0) begin
                w_pany = 1'b1; w_pidx = IW'(i);
            end
        end
    end

    // a later active frame still to be flushed
    logic w_more;
    always_comb begin
        w_more = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (IW'(i) > r_scan && CW'(i) < w_n && r_pin[i] == 8'd0 &&
                r_valid[i] && r_dirty[i]) w_more = 1'b1;
        end
    end

    // status to controller
    logic w_emit;
    assign w_emit = r_pin[r_scan] == 8'd0 && r_valid[r_scan] && r_dirty[r_scan];
    assign o_sts.is_flush  = r_func == bpfm_pkg::F_FLUSH;
    assign o_sts.scan_emit = w_emit;
    assign o_sts.scan_done = CW'(r_scan) + CW'(1) >= w_n;
    assign o_sts.tail_need = r_pinned_any || !r_wrote;
    assign o_sts.out_free  = !r_out_v || i_res_ready;

    logic [IW-1:0] w_next_fifo;
    assign w_next_fifo = (CW'(r_vidx) + CW'(1) >= w_n) ? '0 : r_vidx + IW'(1);

    // result word for the current command
    always_comb begin
        n_out = '0;
        n_out.read_total  = r_reads;
        n_out.write_total = r_writes;
        n_out.last        = 1'b1;
        if (i_cmd.scan) begin
            n_out.frame_index = 4'(r_scan);
            n_out.write_valid = 1'b1;
            n_out.write_page  = r_page[r_scan];
            n_out.write_total = r_writes + 32'd1;
            n_out.last        = !w_more && !r_pinned_any;
        end else if (i_cmd.tail) begin
            n_out.status      = r_pinned_any ? bpfm_pkg::ST_PINNED : bpfm_pkg::ST_OK;
            n_out.frame_index = r_pinned_any ? 4'(r_pinned_idx) : 4'd0;
        end else begin
            unique case (r_func)
                bpfm_pkg::F_PIN: begin
                    if (r_found) begin
                        n_out.frame_index = 4'(r_fidx);
                        n_out.hit         = 1'b1;
                    end else if (!r_vfound) begin
                        n_out.status = bpfm_pkg::ST_FULL;
                    end else begin
                        n_out.frame_index = 4'(r_vidx);
                        n_out.read_valid  = 1'b1;
                        n_out.read_page   = r_pg;
                        n_out.read_total  = r_reads + 32'd1;
                        if (r_valid[r_vidx] && r_dirty[r_vidx]) begin
                            n_out.write_valid = 1'b1;
                            n_out.write_page  = r_page[r_vidx];
                            n_out.write_total = r_writes + 32'd1;
                        end
                    end
                end
                bpfm_pkg::F_UNPIN, bpfm_pkg::F_DIRTY, bpfm_pkg::F_FORCE: begin
                    if (!r_found) begin
                        n_out.status = bpfm_pkg::ST_ABSENT;
                    end else begin
                        n_out.frame_index = 4'(r_fidx);
                        if (r_func == bpfm_pkg::F_FORCE) begin
                            n_out.write_valid = 1'b1;
                            n_out.write_page  = r_page[r_fidx];
                            n_out.write_total = r_writes + 32'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_dirty <= '0;
            r_clock <= '0; r_reads <= '0; r_writes <= '0; r_fifo <= '0;
            r_mode <= 1'b0; r_pool <= 5'd16; r_out_v <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_pin[i] <= '0; r_stamp[i] <= '0; r_page[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bpfm_pkg::CFG_MODE) r_mode <= i_cfg_data[0];
                else if (i_cfg_idx == bpfm_pkg::CFG_POOL) r_pool <= i_cfg_data;
            end
            if (i_cmd.send) r_out_v <= 1'b1;
            else if (i_res_ready) r_out_v <= 1'b0;
            if (i_cmd.send) begin
                r_reads  <= n_out.read_total;
                r_writes <= n_out.write_total;
            end
            // flush step
            if (i_cmd.scan && w_emit) r_dirty[r_scan] <= 1'b0;
            // request execution
            if (i_cmd.exec) begin
                unique case (r_func)
                    bpfm_pkg::F_PIN: begin
                        if (r_found) begin
                            if (r_pin[r_fidx] != 8'hff) r_pin[r_fidx] <= r_pin[r_fidx] + 8'd1;
                            r_clock <= r_clock + 32'd1;
                            r_stamp[r_fidx] <= r_clock + 32'd1;
                        end else if (r_vfound) begin
                            if (!r_mode) r_fifo <= w_next_fifo;
                            r_page[r_vidx]  <= r_pg;
                            r_valid[r_vidx] <= 1'b1;
                            r_dirty[r_vidx] <= 1'b0;
                            r_pin[r_vidx]   <= 8'd1;
                            r_clock <= r_clock + 32'd1;
                            r_stamp[r_vidx] <= r_clock + 32'd1;
                        end
                    end
                    bpfm_pkg::F_UNPIN: begin
                        if (r_found && r_pin[r_fidx] != 8'd0)
                            r_pin[r_fidx] <= r_pin[r_fidx] - 8'd1;
                    end
                    bpfm_pkg::F_DIRTY: if (r_found) r_dirty[r_fidx] <= 1'b1;
                    bpfm_pkg::F_FORCE: if (r_found) r_dirty[r_fidx] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // request and lookup capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_req.func;
            r_pg   <= i_req.page_number;
        end
        if (!i_cmd.latch && !i_cmd.scan) begin
            r_found <= w_found; r_fidx <= w_fidx;
            r_vfound <= w_vfound; r_vidx <= w_vidx;
            r_pinned_any <= w_pany; r_pinned_idx <= w_pidx;
        end
        if (i_cmd.latch) begin
            r_scan <= '0; r_wrote <= 1'b0;
        end else if (i_cmd.scan) begin
            if (w_emit) r_wrote <= 1'b1;
            if (!o_sts.scan_done) r_scan <= r_scan + IW'(1);
        end
        if (i_cmd.send) r_out <= n_out;
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // counters only move when a word is sent
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.send) |-> $stable(r_reads)) else $error("read count moved");
    // flush never clears a pinned frame
    a_flush_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && w_emit) |-> r_pin[r_scan] == 8'd0) else $error("pinned flush");
    // a held word stays while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_res_ready) |=> $stable(r_out)) else $error("word lost");

endmodule

FILE: tb/buffer_pool_frame_manager_top_tb.sv
// ============================================================================
// buffer_pool_frame_manager_top_tb
// Self-checking bench for the page frame manager
// ============================================================================
// A scoreboard keeps its own copy of the frame table. It predicts the result
// words of every accepted request and compares each output word, field by
// field, with the oldest prediction. The stimulus covers these parts:
//   - directed requests
//   - pin counts held at zero and the case where every frame is pinned
//   - random phases under several modes and pool sizes, including the
//     out-of-range pool sizes
// The phases vary sender gaps and receiver stalls, and one phase
// holds the output off for a long stretch.
// ============================================================================
module buffer_pool_frame_manager_top_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 40;
    localparam int PB           = bpfm_pkg::PAGE_BITS;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [bpfm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bpfm_pkg::CFG_BITS-1:0]  cfg_data  = '0;

    bpfm_if #(.T(bpfm_pkg::t_request)) in_if ();
    bpfm_if #(.T(bpfm_pkg::t_result))  out_if ();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    buffer_pool_frame_manager_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_if),
        .out_ch     (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // frame table model and expected words
    class frame_scoreboard;
        logic                 lru_mode;
        logic [4:0]           pool_reg;
        logic [PB-1:0]        page_of [bpfm_pkg::FRAMES];
        logic                 valid_of [bpfm_pkg::FRAMES];
        logic                 dirty_of [bpfm_pkg::FRAMES];
        logic [7:0]           pins_of [bpfm_pkg::FRAMES];
        logic [31:0]          stamp_of [bpfm_pkg::FRAMES];
        logic [31:0]          clock_now;
        logic [3:0]           fifo_ptr;
        logic [31:0]          reads_cnt;
        logic [31:0]          writes_cnt;
        bpfm_pkg::t_result    pending_words[$];
        int                   errors;

        function new();
            errors = 0;
            lru_mode = 1'b0;
            pool_reg = 5'd16;
            clock_now = '0;
            fifo_ptr = '0;
            reads_cnt = '0;
            writes_cnt = '0;
            for (int i = 0; i < bpfm_pkg::FRAMES; i++) begin
                page_of[i] = '0;
                valid_of[i] = 1'b0;
                dirty_of[i] = 1'b0;
                pins_of[i] = '0;
                stamp_of[i] = '0;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0d: %s", cycle_count, msg);
            errors++;
        endtask

        function void set_reg(logic [bpfm_pkg::CFG_IDX_W-1:0] idx,
                              logic [bpfm_pkg::CFG_BITS-1:0] val);
            if (idx == bpfm_pkg::CFG_MODE) lru_mode = val[0];
            else pool_reg = val;
        endfunction

        function int active_count();
            if (pool_reg == 5'd0) return 1;
            if (int'(pool_reg) > bpfm_pkg::FRAMES) return bpfm_pkg::FRAMES;
            return int'(pool_reg);
        endfunction

        function void push_word(logic [1:0] st, int fr, logic ht, logic rv,
                                logic [PB-1:0] rp, logic wv,
                                logic [PB-1:0] wp, logic lst);
            bpfm_pkg::t_result w;
            w.status = st;
            w.frame_index = fr[3:0];
            w.hit = ht;
            w.read_valid = rv;
            w.read_page = rp;
            w.write_valid = wv;
            w.write_page = wp;
            w.last = lst;
            w.read_total = reads_cnt;
            w.write_total = writes_cnt;
            pending_words.push_back(w);
        endfunction

        function int lookup(logic [PB-1:0] pg, int n);
            for (int i = 0; i < n; i++)
                if (valid_of[i] && page_of[i] == pg) return i;
            return -1;
        endfunction

        function int choose_victim(int n);
            int p;
            int best;
            best = -1;
            if (!lru_mode) begin
                p = int'(fifo_ptr) % n;
                for (int i = 0; i < n; i++) begin
                    if (pins_of[p] == 8'd0) return p;
                    p = (p + 1) % n;
                end
                return -1;
            end
            for (int i = 0; i < n; i++)
                if (pins_of[i] == 8'd0 && !valid_of[i]) return i;
            for (int i = 0; i < n; i++) begin
                if (pins_of[i] != 8'd0) continue;
                if (best < 0 || stamp_of[i] < stamp_of[best]) best = i;
            end
            return best;
        endfunction

        // predict the words of one accepted request
        function void note_request(bpfm_pkg::t_request rq);
            int n;
            int f;
            int pinned;
            int k;
            logic wv;
            logic [PB-1:0] wp;
            n = active_count();
            case (rq.func)
                bpfm_pkg::F_PIN: begin
                    f = lookup(rq.page_number, n);
                    if (f >= 0) begin
                        if (pins_of[f] != 8'd255) pins_of[f]++;
                        clock_now++;
                        stamp_of[f] = clock_now;
                        push_word(bpfm_pkg::ST_OK, f, 1'b1, 1'b0, '0, 1'b0, '0, 1'b1);
                    end else begin
                        f = choose_victim(n);
                        if (f < 0) begin
                            push_word(bpfm_pkg::ST_FULL, 0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                        end else begin
                            if (!lru_mode) fifo_ptr = 4'((f + 1) % n);
                            wv = 1'b0;
                            wp = '0;
                            if (valid_of[f] && dirty_of[f]) begin
                                wv = 1'b1;
                                wp = page_of[f];
                                writes_cnt++;
                            end
                            reads_cnt++;
                            page_of[f] = rq.page_number;
                            valid_of[f] = 1'b1;
                            dirty_of[f] = 1'b0;
                            pins_of[f] = 8'd1;
                            clock_now++;
                            stamp_of[f] = clock_now;
                            push_word(bpfm_pkg::ST_OK, f, 1'b0, 1'b1, rq.page_number,
                                      wv, wp, 1'b1);
                        end
                    end
                end
                bpfm_pkg::F_FLUSH: begin
                    k = 0;
                    pinned = -1;
                    for (int i = 0; i < n; i++) begin
                        if (pins_of[i] != 8'd0) begin
                            if (pinned < 0) pinned = i;
                        end else if (valid_of[i] && dirty_of[i]) begin
                            dirty_of[i] = 1'b0;
                            writes_cnt++;
                            push_word(bpfm_pkg::ST_OK, i, 1'b0, 1'b0, '0, 1'b1,
                                      page_of[i], 1'b0);
                            k++;
                        end
                    end
                    if (pinned >= 0)
                        push_word(bpfm_pkg::ST_PINNED, pinned, 1'b0, 1'b0, '0, 1'b0, '0,
                                  1'b1);
                    else if (k == 0)
                        push_word(bpfm_pkg::ST_OK, 0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                    else pending_words[$].last = 1'b1;
                end
                bpfm_pkg::F_UNPIN, bpfm_pkg::F_DIRTY, bpfm_pkg::F_FORCE: begin
                    f = lookup(rq.page_number, n);
                    if (f < 0) begin
                        push_word(bpfm_pkg::ST_ABSENT, 0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                    end else if (rq.func == bpfm_pkg::F_UNPIN) begin
                        if (pins_of[f] != 8'd0) pins_of[f]--;
                        push_word(bpfm_pkg::ST_OK, f, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                    end else if (rq.func == bpfm_pkg::F_DIRTY) begin
                        dirty_of[f] = 1'b1;
                        push_word(bpfm_pkg::ST_OK, f, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                    end else begin
                        dirty_of[f] = 1'b0;
                        writes_cnt++;
                        push_word(bpfm_pkg::ST_OK, f, 1'b0, 1'b0, '0, 1'b1, page_of[f],
                                  1'b1);
                    end
                end
                default: push_word(bpfm_pkg::ST_OK, 0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
            endcase
        endfunction

        // compare one output word with the oldest prediction
        task check_word(bpfm_pkg::t_result got);
            bpfm_pkg::t_result exp_w;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.status != exp_w.status)
                report($sformatf("status %0d exp %0d", got.status, exp_w.status));
            if (got.frame_index != exp_w.frame_index)
                report($sformatf("frame_index %0d exp %0d", got.frame_index,
                                 exp_w.frame_index));
            if (got.hit != exp_w.hit)
                report($sformatf("hit %0d exp %0d", got.hit, exp_w.hit));
            if (got.read_valid != exp_w.read_valid)
                report($sformatf("read_valid %0d exp %0d", got.read_valid,
                                 exp_w.read_valid));
            if (got.read_page != exp_w.read_page)
                report($sformatf("read_page %h exp %h", got.read_page, exp_w.read_page));
            if (got.write_valid != exp_w.write_valid)
                report($sformatf("write_valid %0d exp %0d", got.write_valid,
                                 exp_w.write_valid));
            if (got.write_page != exp_w.write_page)
                report($sformatf("write_page %h exp %h", got.write_page,
                                 exp_w.write_page));
            if (got.last != exp_w.last)
                report($sformatf("last %0d exp %0d", got.last, exp_w.last));
            if (got.read_total != exp_w.read_total)
                report($sformatf("read_total %0d exp %0d", got.read_total,
                                 exp_w.read_total));
            if (got.write_total != exp_w.write_total)
                report($sformatf("write_total %0d exp %0d", got.write_total,
                                 exp_w.write_total));
        endtask
    endclass

    frame_scoreboard frame_sb = new();

    // watch both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) frame_sb.note_request(in_if.data);
            if (out_if.valid && out_if.ready) frame_sb.check_word(out_if.data);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
    end

    // offer one word; valid stays high unless a gap follows
    task send_word(logic [2:0] fn, logic [PB-1:0] pg);
        bpfm_pkg::t_request rq;
        rq.func = fn;
        rq.page_number = pg;
        if ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.data <= rq;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // drop valid and wait for every expected word, then let the block settle
    task drain_all();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (frame_sb.pending_words.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_reg(logic [bpfm_pkg::CFG_IDX_W-1:0] idx, logic [bpfm_pkg::CFG_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        frame_sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random requests over a page range near the pool size
    task random_requests(int count);
        int r;
        logic [2:0] fn;
        logic [PB-1:0] pg;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 38) fn = bpfm_pkg::F_PIN;
            else if (r < 63) fn = bpfm_pkg::F_UNPIN;
            else if (r < 78) fn = bpfm_pkg::F_DIRTY;
            else if (r < 87) fn = bpfm_pkg::F_FORCE;
            else if (r < 95) fn = bpfm_pkg::F_FLUSH;
            else fn = 3'($urandom_range(7, 5));
            r = $urandom_range(99);
            if (r < 8) pg = PB'($urandom);
            else if (r < 12) pg = '1;
            else pg = PB'($urandom_range(frame_sb.active_count() + 4));
            send_word(fn, pg);
        end
    endtask

    task set_idling(int tx, int rx);
        tx_idle_pct = tx;
        rx_stall_pct = rx;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every request and the not-resident answers
        send_word(bpfm_pkg::F_PIN, '0);
        send_word(bpfm_pkg::F_PIN, '1);
        send_word(bpfm_pkg::F_PIN, '0);
        send_word(bpfm_pkg::F_DIRTY, '1);
        send_word(bpfm_pkg::F_FORCE, '0);
        send_word(bpfm_pkg::F_UNPIN, '0);
        send_word(bpfm_pkg::F_UNPIN, '0);
        send_word(bpfm_pkg::F_UNPIN, '0);
        send_word(bpfm_pkg::F_UNPIN, 20'h5);
        send_word(bpfm_pkg::F_DIRTY, 20'h5);
        send_word(bpfm_pkg::F_FORCE, 20'h5);
        send_word(3'd5, 20'h5);
        send_word(3'd6, '1);
        send_word(3'd7, 20'hA5A5A);
        send_word(bpfm_pkg::F_DIRTY, '0);
        send_word(bpfm_pkg::F_FLUSH, '1);
        send_word(bpfm_pkg::F_UNPIN, '1);
        send_word(bpfm_pkg::F_FLUSH, '0);
        send_word(bpfm_pkg::F_FLUSH, '0);
        drain_all();

        // one frame: a further miss finds no free frame, unpin stops at zero
        write_reg(bpfm_pkg::CFG_POOL, 5'd1);
        write_reg(bpfm_pkg::CFG_MODE, 5'd1);
        for (int i = 0; i < 3; i++) send_word(bpfm_pkg::F_PIN, 20'h00077);
        send_word(bpfm_pkg::F_PIN, 20'h00078);
        send_word(bpfm_pkg::F_FLUSH, '0);
        for (int i = 0; i < 4; i++) send_word(bpfm_pkg::F_UNPIN, 20'h00077);
        drain_all();

        // random phases over mode, pool size and idling
        write_reg(bpfm_pkg::CFG_MODE, 5'd0);
        write_reg(bpfm_pkg::CFG_POOL, 5'd16);
        set_idling(0, 0);
        random_requests(20);
        drain_all();

        write_reg(bpfm_pkg::CFG_MODE, 5'd1);
        write_reg(bpfm_pkg::CFG_POOL, 5'd4);
        set_idling(45, 0);
        random_requests(20);
        drain_all();

        write_reg(bpfm_pkg::CFG_MODE, 5'd0);
        write_reg(bpfm_pkg::CFG_POOL, 5'd0);
        set_idling(0, 45);
        random_requests(20);
        drain_all();

        write_reg(bpfm_pkg::CFG_MODE, 5'd1);
        write_reg(bpfm_pkg::CFG_POOL, 5'd31);
        set_idling(32, 32);
        random_requests(20);
        drain_all();

        // long output hold-off while requests keep coming
        write_reg(bpfm_pkg::CFG_POOL, 5'd16);
        set_idling(0, 0);
        hold_left <= 300;
        random_requests(20);
        drain_all();

        write_reg(bpfm_pkg::CFG_MODE, 5'd0);
        write_reg(bpfm_pkg::CFG_POOL, 5'd8);
        set_idling(32, 32);
        random_requests(20);
        drain_all();

        if (frame_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
